FILE: design/btmx_pkg.sv
package btmx_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic load;
		logic clear;
		logic walk_step;
		logic need_set;
		logic link;
		logic fill;
		logic query_step;
		logic set_empty;
		logic set_full;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       root_empty;
		logic       walk_null;
		logic       query_stop;
		logic       last;
		logic       full;
		logic       out_free;
	} stat_t;

endpackage

FILE: design/btmx_dpath.sv
module btmx_dpath #(
	parameter int KEY_BITS  = 30,
	parameter int NODE_POOL = 8192
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  btmx_pkg::cmd_t         cmd,
	output btmx_pkg::stat_t        stat,
	input  logic [1:0]             opcode,
	input  logic [KEY_BITS-1:0]    key,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [KEY_BITS-1:0]    max_xor,
	output logic [1:0]             status
);

	localparam int IDX_W  = $clog2(NODE_POOL);
	localparam int ENT_W  = 2 * IDX_W;
	localparam int CNT_W  = IDX_W + 1;
	localparam int SUM_W  = IDX_W + 2;
	localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int NEED_W = LVL_W + 1;
	localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(KEY_BITS - 1);
	localparam logic [SUM_W-1:0] POOL_LIM = SUM_W'(NODE_POOL);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [ENT_W-1:0]    node_mem_q [NODE_POOL];
	logic [ENT_W-1:0]    rd_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_sh_q;
	logic [LVL_W-1:0]    lvl_q;
	logic                at_root_q;
	logic [IDX_W-1:0]    cur_q;
	logic [KEY_BITS-1:0] acc_q;
	logic [1:0]          stat_q;
	logic [NEED_W-1:0]   need_q;
	logic [IDX_W-1:0]    root0_q;
	logic [IDX_W-1:0]    root1_q;
	logic [CNT_W-1:0]    nodes_q;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] max_xor_q;
	logic [1:0]          status_q;

	logic [KEY_BITS-1:0] key_nx;
	logic                msb;
	logic                nbit;
	logic [IDX_W-1:0]    kid0;
	logic [IDX_W-1:0]    kid1;
	logic [IDX_W-1:0]    same;
	logic [IDX_W-1:0]    opp;
	logic                same_hit;
	logic                opp_hit;
	logic [IDX_W-1:0]    nxt;
	logic [IDX_W-1:0]    new_idx;
	logic [IDX_W-1:0]    new_nx;
	logic                rd_en;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ENT_W-1:0]    wr_data;
	logic [ENT_W-1:0]    link_data;
	logic [ENT_W-1:0]    fill_data;
	logic                step;

	assign msb      = key_sh_q[KEY_BITS-1];
	assign key_nx   = key_sh_q << 1;
	assign nbit     = key_nx[KEY_BITS-1];
	assign kid0     = at_root_q ? root0_q : rd_q[IDX_W-1:0];
	assign kid1     = at_root_q ? root1_q : rd_q[ENT_W-1:IDX_W];
	assign same     = msb ? kid1 : kid0;
	assign opp      = msb ? kid0 : kid1;
	assign same_hit = (same != '0);
	assign opp_hit  = (opp != '0);
	assign nxt      = (cmd.query_step && opp_hit) ? opp : same;
	assign new_idx  = nodes_q[IDX_W-1:0];
	assign new_nx   = new_idx + 1'b1;
	assign step     = cmd.walk_step || cmd.query_step;
	assign rd_en    = step;

	assign link_data = msb ? {new_idx, kid0} : {kid1, new_idx};
	always_comb begin
		if (lvl_q == '0) begin
			fill_data = '0;
		end else if (nbit) begin
			fill_data = {new_nx, {IDX_W{1'b0}}};
		end else begin
			fill_data = {{IDX_W{1'b0}}, new_nx};
		end
	end

	assign wr_en   = (cmd.link && !at_root_q) || cmd.fill;
	assign wr_addr = cmd.fill ? new_idx : cur_q;
	assign wr_data = cmd.fill ? fill_data : link_data;

	// node store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= node_mem_q[nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root0_q     <= '0;
			root1_q     <= '0;
			nodes_q     <= CNT_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				root0_q <= '0;
				root1_q <= '0;
				nodes_q <= CNT_ONE;
			end
			if (cmd.link && at_root_q) begin
				if (msb) begin
					root1_q <= new_idx;
				end else begin
					root0_q <= new_idx;
				end
			end
			if (cmd.fill) begin
				nodes_q <= nodes_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			key_sh_q  <= key;
			lvl_q     <= LVL_TOP;
			at_root_q <= 1'b1;
			cur_q     <= '0;
			acc_q     <= '0;
			stat_q    <= btmx_pkg::ST_OK;
		end
		if (step) begin
			key_sh_q  <= key_nx;
			lvl_q     <= lvl_q - 1'b1;
			at_root_q <= 1'b0;
			cur_q     <= nxt;
		end
		if (cmd.query_step && opp_hit) begin
			acc_q[lvl_q] <= 1'b1;
		end
		if (cmd.need_set) begin
			need_q <= NEED_W'(lvl_q) + 1'b1;
		end
		if (cmd.fill) begin
			key_sh_q <= key_nx;
			lvl_q    <= lvl_q - 1'b1;
		end
		if (cmd.set_empty) begin
			stat_q <= btmx_pkg::ST_EMPTY;
		end
		if (cmd.set_full) begin
			stat_q <= btmx_pkg::ST_FULL;
		end
		if (cmd.out_load) begin
			max_xor_q <= acc_q;
			status_q  <= stat_q;
		end
	end

	assign stat.op         = op_q;
	assign stat.root_empty = (root0_q == '0) && (root1_q == '0);
	assign stat.walk_null  = !same_hit;
	assign stat.query_stop = !same_hit && !opp_hit;
	assign stat.last       = (lvl_q == '0);
	assign stat.full       = (SUM_W'(nodes_q) + SUM_W'(need_q)) > POOL_LIM;
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign max_xor   = max_xor_q;
	assign status    = status_q;

endmodule

FILE: design/btmx_ctrl.sv
module btmx_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  btmx_pkg::stat_t stat,
	output btmx_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_START  = 8'b0000_0010,
		S_WALK   = 8'b0000_0100,
		S_CHECK  = 8'b0000_1000,
		S_LINK   = 8'b0001_0000,
		S_FILL   = 8'b0010_0000,
		S_QUERY  = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_START;
				end
			end
			S_START: begin
				unique case (stat.op)
					btmx_pkg::OP_INSERT: begin
						state_nx = S_WALK;
					end
					btmx_pkg::OP_QUERY: begin
						if (stat.root_empty) begin
							cmd.set_empty = 1'b1;
							state_nx      = S_FINISH;
						end else begin
							state_nx = S_QUERY;
						end
					end
					btmx_pkg::OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_nx  = S_FINISH;
					end
					default: begin
						state_nx = S_FINISH;
					end
				endcase
			end
			S_WALK: begin
				if (stat.walk_null) begin
					cmd.need_set = 1'b1;
					state_nx     = S_CHECK;
				end else begin
					cmd.walk_step = 1'b1;
					if (stat.last) begin
						state_nx = S_FINISH;
					end
				end
			end
			S_CHECK: begin
				if (stat.full) begin
					cmd.set_full = 1'b1;
					state_nx     = S_FINISH;
				end else begin
					state_nx = S_LINK;
				end
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_nx = S_FILL;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.last) begin
					state_nx = S_FINISH;
				end
			end
			S_QUERY: begin
				if (stat.query_stop) begin
					state_nx = S_FINISH;
				end else begin
					cmd.query_step = 1'b1;
					if (stat.last) begin
						state_nx = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/binary_trie_max_xor_unit.sv
// channel | handshake           | payload
// --------+---------------------+----------------------------
// in      | in_valid / in_stall | opcode[1:0], key[KEY_BITS-1:0]
// out     | out_valid/out_stall | max_xor[KEY_BITS-1:0], status[1:0]
//
// One beat at a time. Insert walks down until a child is missing, then writes one
// new node per level left. The node memory, one write port and one registered read
// port, sets the pace: one trie level or one node write per cycle.
// Reset empties the trie at once; node memory needs no clearing.
// A stalled result sits in the output register while the next beat runs.
module binary_trie_max_xor_unit #(
	parameter int KEY_BITS  = 30,
	parameter int NODE_POOL = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [KEY_BITS-1:0] key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KEY_BITS-1:0] max_xor,
	output logic [1:0]          status
);

	btmx_pkg::cmd_t  cmd;
	btmx_pkg::stat_t stat;

	btmx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	btmx_dpath #(
		.KEY_BITS  (KEY_BITS),
		.NODE_POOL (NODE_POOL)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.key       (key),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.max_xor   (max_xor),
		.status    (status)
	);

endmodule
